FILE: design/single_tap_panned_delay_core_defines.svh
// assertion macros for the single tap panned delay core checker
`ifndef SINGLE_TAP_PANNED_DELAY_CORE_DEFINES_SVH
`define SINGLE_TAP_PANNED_DELAY_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define STPD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define STPD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/stpd_pkg.sv
// shared types and constants of the single tap panned delay core
package stpd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int DELAY_W  = 10;
	localparam int COEF_W   = 16;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 2;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_TAP_ENABLE = 2'd0;
	localparam logic [IDX_W-1:0] REG_TAP_DELAY  = 2'd1;
	localparam logic [IDX_W-1:0] REG_TAP_GAIN   = 2'd2;
	localparam logic [IDX_W-1:0] REG_TAP_PAN    = 2'd3;

	localparam logic [COEF_W-1:0] GAIN_RESET = 16'd32768;
	localparam logic [COEF_W-1:0] PAN_RESET  = 16'd16384;
	localparam logic [COEF_W-1:0] PAN_UNITY  = 16'd32768;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QLW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic                tap_enable;
		logic [DELAY_W-1:0]  tap_delay;
		logic [COEF_W-1:0]   tap_gain;
		logic [COEF_W-1:0]   tap_pan;
	} cfg_t;

endpackage

FILE: design/stpd_queue.sv
// small fifo that decouples the store front from the arithmetic back
module stpd_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [stpd_pkg::SAMPLE_W-1:0]   push_data,
	input  logic                            pop,
	output logic                            out_valid,
	output logic [stpd_pkg::SAMPLE_W-1:0]   out_data,
	output logic [stpd_pkg::QLW-1:0]        level
);

	logic [stpd_pkg::SAMPLE_W-1:0] ent_q [stpd_pkg::QDEPTH];
	logic [stpd_pkg::QPW-1:0]      wr_ptr_q;
	logic [stpd_pkg::QPW-1:0]      rd_ptr_q;
	logic [stpd_pkg::QLW-1:0]      level_q;

	assign out_valid = (level_q != '0);
	assign out_data  = ent_q[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/stpd_front.sv
// front end: accepts samples, writes the circular store and reads the tap
module stpd_front #(
	parameter int DEPTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  stpd_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [stpd_pkg::SAMPLE_W-1:0]   in_sample,
	input  logic [stpd_pkg::QLW-1:0]        q_level,
	output logic                            push,
	output logic [stpd_pkg::SAMPLE_W-1:0]   push_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [stpd_pkg::SAMPLE_W-1:0] mem [DEPTH];

	logic [AW-1:0]                 wp_q;
	logic [CW-1:0]                 fill_q;
	logic                          valid_s1;
	logic                          zero_s1;
	logic                          byp_s1;
	logic [stpd_pkg::SAMPLE_W-1:0] byp_data_s1;
	logic [stpd_pkg::SAMPLE_W-1:0] rdata_s1;

	logic                          acc;
	logic [31:0]                   d_ext;
	logic [AW-1:0]                 d_a;
	logic [AW:0]                   rd_wrap;
	logic [AW-1:0]                 rd_addr;
	logic                          unwritten;

	// room for the item in flight plus one more in the queue
	assign in_ready = (({1'b0, q_level} + {{stpd_pkg::QLW{1'b0}}, valid_s1})
		< (stpd_pkg::QLW + 1)'(stpd_pkg::QDEPTH));
	assign acc = in_valid && in_ready;

	// a delay at or past the store depth counts as zero
	assign d_ext   = {{(32 - stpd_pkg::DELAY_W){1'b0}}, cfg.tap_delay};
	assign d_a     = (d_ext >= 32'(DEPTH)) ? '0 : d_ext[AW-1:0];
	assign rd_wrap = {1'b0, wp_q} + (AW + 1)'(DEPTH) - {1'b0, d_a};
	assign rd_addr = (wp_q >= d_a) ? (wp_q - d_a) : rd_wrap[AW-1:0];

	// entries beyond the fill count have never been written and read as zero
	assign unwritten = (CW'(d_a) > fill_q);

	always_ff @(posedge clk) begin
		if (acc) begin
			mem[wp_q]   <= in_sample;
			rdata_s1    <= mem[rd_addr];
			byp_data_s1 <= in_sample;
			byp_s1      <= (d_a == '0);
			zero_s1     <= !cfg.tap_enable || unwritten;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (acc) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
				if (fill_q != CW'(DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	assign push      = valid_s1;
	assign push_data = zero_s1 ? '0 : (byp_s1 ? byp_data_s1 : rdata_s1);

endmodule

FILE: design/stpd_back.sv
// back end: gain and pan multiplies, rounding, saturation and output register
module stpd_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  stpd_pkg::cfg_t                  cfg,
	input  logic                            q_valid,
	input  logic [stpd_pkg::SAMPLE_W-1:0]   q_data,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2*stpd_pkg::SAMPLE_W-1:0] out_data
);

	localparam int SG_W = stpd_pkg::SAMPLE_W + stpd_pkg::COEF_W + 1;
	localparam int P_W  = SG_W + stpd_pkg::COEF_W + 1;

	function automatic logic [stpd_pkg::SAMPLE_W-1:0] round_sat(
		input logic signed [P_W-1:0] p
	);
		logic signed [P_W-1:0] t;
		logic signed [P_W-31:0] r;
		begin
			t = p + (P_W)'(64'd536870912);
			r = t[P_W-1:30];
			if (r > (P_W - 30)'(32767)) begin
				round_sat = 16'h7fff;
			end else if (r < -(P_W - 30)'(32768)) begin
				round_sat = 16'h8000;
			end else begin
				round_sat = r[stpd_pkg::SAMPLE_W-1:0];
			end
		end
	endfunction

	logic signed [SG_W-1:0]          sg_s2;
	logic                            valid_s2;
	logic signed [P_W-1:0]           pl_s3;
	logic signed [P_W-1:0]           pr_s3;
	logic                            valid_s3;
	logic                            out_valid_q;
	logic [2*stpd_pkg::SAMPLE_W-1:0] out_data_q;

	logic                            out_free;
	logic                            adv3;
	logic                            free3;
	logic                            adv2;
	logic                            free2;

	logic signed [stpd_pkg::SAMPLE_W-1:0] s_sig;
	logic signed [stpd_pkg::COEF_W:0]     g_sig;
	logic [stpd_pkg::COEF_W-1:0]          pan_f;
	logic signed [stpd_pkg::COEF_W:0]     pr_f;
	logic signed [stpd_pkg::COEF_W:0]     pl_f;
	logic signed [SG_W-1:0]               sg_w;
	logic signed [P_W-1:0]                pl_w;
	logic signed [P_W-1:0]                pr_w;

	assign out_free = !out_valid_q || out_ready;
	assign adv3     = valid_s3 && out_free;
	assign free3    = !valid_s3 || out_free;
	assign adv2     = valid_s2 && free3;
	assign free2    = !valid_s2 || free3;
	assign pop      = q_valid && free2;

	// pan above unity is held at full right
	assign pan_f = (cfg.tap_pan > stpd_pkg::PAN_UNITY) ? stpd_pkg::PAN_UNITY : cfg.tap_pan;
	assign pr_f  = {1'b0, pan_f};
	assign pl_f  = {1'b0, stpd_pkg::PAN_UNITY - pan_f};
	assign s_sig = q_data;
	assign g_sig = {1'b0, cfg.tap_gain};
	assign sg_w  = s_sig * g_sig;
	assign pl_w  = sg_s2 * pl_f;
	assign pr_w  = sg_s2 * pr_f;

	always_ff @(posedge clk) begin
		if (pop) begin
			sg_s2 <= sg_w;
		end
		if (adv2) begin
			pl_s3 <= pl_w;
			pr_s3 <= pr_w;
		end
		if (adv3) begin
			out_data_q <= {round_sat(pr_s3), round_sat(pl_s3)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free2) begin
				valid_s2 <= q_valid;
			end
			if (free3) begin
				valid_s3 <= valid_s2;
			end
			if (out_free) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: design/single_tap_panned_delay_core.sv
// a sample passes the front stage, the queue, stages s2 and s3 and the output register
// throughput: one sample per cycle while m_tready holds; one store write and one
// tap read each accepted cycle, on a separate write port and read port
// a four-entry queue lets the store front run on while the output stalls
// reset clears all control state and loads the register reset values; data registers keep
// their contents; entries never written read as zero through a fill count, so no clearing
// pass runs and samples are taken at once
module single_tap_panned_delay_core #(
	parameter int DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [stpd_pkg::SAMPLE_W-1:0]     s_tdata,   // [15:0] sample_in
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [2*stpd_pkg::SAMPLE_W-1:0]   m_tdata,   // [15:0] left_out, [31:16] right_out
	input  logic                              wr_en,
	input  logic [stpd_pkg::IDX_W-1:0]        wr_index,
	input  logic [stpd_pkg::CFG_W-1:0]        wr_data
);

	stpd_pkg::cfg_t                  cfg_q;
	logic                            push;
	logic [stpd_pkg::SAMPLE_W-1:0]   push_data;
	logic                            pop;
	logic                            q_valid;
	logic [stpd_pkg::SAMPLE_W-1:0]   q_data;
	logic [stpd_pkg::QLW-1:0]        q_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_enable <= 1'b0;
			cfg_q.tap_delay  <= '0;
			cfg_q.tap_gain   <= stpd_pkg::GAIN_RESET;
			cfg_q.tap_pan    <= stpd_pkg::PAN_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				stpd_pkg::REG_TAP_ENABLE: cfg_q.tap_enable <= wr_data[0];
				stpd_pkg::REG_TAP_DELAY:  cfg_q.tap_delay  <= wr_data[stpd_pkg::DELAY_W-1:0];
				stpd_pkg::REG_TAP_GAIN:   cfg_q.tap_gain   <= wr_data;
				stpd_pkg::REG_TAP_PAN:    cfg_q.tap_pan    <= wr_data;
				default: begin
				end
			endcase
		end
	end

	stpd_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata),
		.q_level   (q_level),
		.push      (push),
		.push_data (push_data)
	);

	stpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.out_valid (q_valid),
		.out_data  (q_data),
		.level     (q_level)
	);

	stpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

FILE: design/stpd_checker.sv
// port-level checker for the single tap panned delay core, with its bind
`include "single_tap_panned_delay_core_defines.svh"

module stpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// front stage, queue and three back registers
	localparam logic [3:0] MAX_OPEN = 4'd7;

	logic [3:0] open_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (in_acc && !out_acc) begin
			open_q <= open_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			open_q <= open_q - 1'b1;
		end
	end

	`STPD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`STPD_ASSERT_IMP(a_no_invented, m_tvalid, open_q != 4'd0, "result without an open request")
	`STPD_ASSERT_IMP(a_bounded, 1'b1, open_q <= MAX_OPEN, "more requests in flight than the core can hold")

endmodule

bind single_tap_panned_delay_core stpd_checker u_stpd_checker (.*);
